/* src/bsl_pkg.sv */
// ----------------------------------------------------------------------------
// bsl_pkg: shared constants for the bounded shift list
// Sizes, operation codes and status codes used by the list and its storage.
// ----------------------------------------------------------------------------
package bsl_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int OP_W       = 3;
    localparam int STAT_W     = 2;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_ERASE      = 3'd4;
    localparam logic [OP_W-1:0] OP_READ       = 3'd5;
    localparam logic [OP_W-1:0] OP_WRITE      = 3'd6;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

endpackage

/* src/bsl_ram.sv */
// ----------------------------------------------------------------------------
// bsl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/bounded_shift_list.sv */
// ----------------------------------------------------------------------------
// bounded_shift_list: fixed-capacity ordered list with shifting insert/erase
// Entries live in a small RAM; one read/write step moves one word at a time.
// ----------------------------------------------------------------------------
// Sequence: every operation ends with the S_FRONT, S_BACK and S_DONE readout
//   states before its result transfer. An accepted push front first shifts words
//   up, and erase and pop front first shift words down, with a RAM read step and
//   a RAM write step per moved word. Throughput: one item at a time; in_stall
//   holds the next input transfer until the result is registered, and longer on output stall.
// Reset: count clears to zero, no result pending; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_shift_list (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bsl_pkg::OP_W-1:0]            operation,
    input  logic [bsl_pkg::DATA_WIDTH-1:0]      value,
    input  logic [bsl_pkg::IDX_W-1:0]           position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bsl_pkg::DATA_WIDTH-1:0]      read_value,
    output logic [bsl_pkg::DATA_WIDTH-1:0]      front_value,
    output logic [bsl_pkg::DATA_WIDTH-1:0]      back_value,
    output logic [bsl_pkg::CNT_W-1:0]           count,
    output logic                                is_empty,
    output logic [bsl_pkg::STAT_W-1:0]          status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UP_RD = 3'd1;
    localparam logic [2:0] S_UP_WR = 3'd2;
    localparam logic [2:0] S_DN_RD = 3'd3;
    localparam logic [2:0] S_DN_WR = 3'd4;
    localparam logic [2:0] S_FRONT = 3'd5;
    localparam logic [2:0] S_BACK  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam int IW = bsl_pkg::IDX_W;
    localparam int CW = bsl_pkg::CNT_W;
    localparam int DW = bsl_pkg::DATA_WIDTH;

    logic [2:0]                 state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [IW-1:0]              idx_reg, idx_next;
    logic [DW-1:0]              val_reg, val_next;
    logic                       rd_ok_reg, rd_ok_next;
    logic [bsl_pkg::STAT_W-1:0] stat_reg, stat_next;
    logic [DW-1:0]              rd_reg, rd_next;
    logic [DW-1:0]              front_reg, front_next;

    logic                       out_valid_reg, out_valid_next;
    logic [DW-1:0]              out_rd_reg, out_rd_next;
    logic [DW-1:0]              out_front_reg, out_front_next;
    logic [DW-1:0]              out_back_reg, out_back_next;
    logic [CW-1:0]              out_count_reg, out_count_next;
    logic                       out_empty_reg, out_empty_next;
    logic [bsl_pkg::STAT_W-1:0] out_stat_reg, out_stat_next;

    logic                       ram_wen;
    logic [IW-1:0]              ram_waddr;
    logic [DW-1:0]              ram_wdata;
    logic [IW-1:0]              ram_raddr;
    logic [DW-1:0]              ram_rdata;

    logic                       in_fire;
    logic                       full;
    logic                       pos_ok;
    logic                       fin_empty;

    bsl_ram #(
        .WIDTH (DW),
        .DEPTH (bsl_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .wen   (ram_wen),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign full      = (count_reg == CW'(bsl_pkg::CAPACITY));
    assign pos_ok    = (CW'(position) < count_reg);
    assign fin_empty = (count_reg == '0);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        rd_ok_next     = rd_ok_reg;
        stat_next      = stat_reg;
        rd_next        = rd_reg;
        front_next     = front_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_rd_next    = out_rd_reg;
        out_front_next = out_front_reg;
        out_back_next  = out_back_reg;
        out_count_next = out_count_reg;
        out_empty_next = out_empty_reg;
        out_stat_next  = out_stat_reg;
        ram_wen        = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // read port looks at position so a read op has data next cycle
                ram_raddr = position;
                if (in_fire)
                begin
                    val_next   = value;
                    stat_next  = bsl_pkg::ST_OK;
                    rd_ok_next = 1'b0;
                    state_next = S_FRONT;
                    unique case (operation)
                        bsl_pkg::OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                stat_next = bsl_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_wen    = 1'b1;
                                ram_waddr  = IW'(count_reg);
                                ram_wdata  = value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bsl_pkg::OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                stat_next = bsl_pkg::ST_FULL;
                            end
                            else
                            begin
                                idx_next   = IW'(count_reg);
                                state_next = S_UP_RD;
                            end
                        end
                        bsl_pkg::OP_POP_BACK:
                        begin
                            if (!fin_empty)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        bsl_pkg::OP_POP_FRONT:
                        begin
                            if (!fin_empty)
                            begin
                                idx_next   = '0;
                                state_next = S_DN_RD;
                            end
                        end
                        bsl_pkg::OP_ERASE:
                        begin
                            if (pos_ok)
                            begin
                                idx_next   = position;
                                state_next = S_DN_RD;
                            end
                            else
                            begin
                                stat_next = bsl_pkg::ST_RANGE;
                            end
                        end
                        bsl_pkg::OP_READ:
                        begin
                            if (pos_ok)
                            begin
                                rd_ok_next = 1'b1;
                            end
                            else
                            begin
                                stat_next = bsl_pkg::ST_RANGE;
                            end
                        end
                        bsl_pkg::OP_WRITE:
                        begin
                            if (pos_ok)
                            begin
                                ram_wen   = 1'b1;
                                ram_waddr = position;
                                ram_wdata = value;
                            end
                            else
                            begin
                                stat_next = bsl_pkg::ST_RANGE;
                            end
                        end
                        bsl_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                // shift up from the back; finish by placing the new word at 0
                if (idx_reg == '0)
                begin
                    ram_wen    = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = val_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_FRONT;
                end
                else
                begin
                    ram_raddr  = idx_reg - IW'(1);
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR:
            begin
                ram_wen    = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg - IW'(1);
                state_next = S_UP_RD;
            end
            S_DN_RD:
            begin
                // close the gap one word at a time, then drop the last entry
                if ((CW'(idx_reg) + CW'(1)) < count_reg)
                begin
                    ram_raddr  = idx_reg + IW'(1);
                    state_next = S_DN_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_FRONT;
                end
            end
            S_DN_WR:
            begin
                ram_wen    = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg + IW'(1);
                state_next = S_DN_RD;
            end
            S_FRONT:
            begin
                rd_next    = rd_ok_reg ? ram_rdata : '0;
                ram_raddr  = '0;
                state_next = S_BACK;
            end
            S_BACK:
            begin
                front_next = ram_rdata;
                ram_raddr  = IW'(count_reg - CW'(1));
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the back address so the read data stays put while stalled
                ram_raddr = IW'(count_reg - CW'(1));
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = rd_reg;
                    out_front_next = fin_empty ? '0 : front_reg;
                    out_back_next  = fin_empty ? '0 : ram_rdata;
                    out_count_next = count_reg;
                    out_empty_next = fin_empty;
                    out_stat_next  = stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        val_reg       <= val_next;
        rd_ok_reg     <= rd_ok_next;
        stat_reg      <= stat_next;
        rd_reg        <= rd_next;
        front_reg     <= front_next;
        out_rd_reg    <= out_rd_next;
        out_front_reg <= out_front_next;
        out_back_reg  <= out_back_next;
        out_count_reg <= out_count_next;
        out_empty_reg <= out_empty_next;
        out_stat_reg  <= out_stat_next;
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = out_rd_reg;
    assign front_value = out_front_reg;
    assign back_value  = out_back_reg;
    assign count       = out_count_reg;
    assign is_empty    = out_empty_reg;
    assign status      = out_stat_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(bsl_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_no_write_late: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FRONT || state_reg == S_BACK || state_reg == S_DONE) |-> !ram_wen)
        else $error("RAM write during front/back readout");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != S_IDLE)
        else $error("sequencer idle after input transfer");

    a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_empty_reg == (out_count_reg == '0)))
        else $error("empty flag disagrees with count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stat_reg == bsl_pkg::ST_FULL)
            |-> out_count_reg == CW'(bsl_pkg::CAPACITY))
        else $error("full status with room left");
`endif

endmodule
